/* hw/rtl/lbg_pkg.sv */
// shared types and constants of the bar graph cell generator
`timescale 1ns / 1ps
package lbg_pkg;

    localparam int MAX_COLUMNS = 40;
    localparam logic [7:0] LEFT_GLYPH = 8'd91;
    localparam logic [7:0] RIGHT_GLYPH = 8'd93;

    localparam int COL_W = 6;
    localparam int ROW_W = 2;
    localparam int GLYPH_W = 8;
    localparam int POS_W = 32;
    localparam int QUOT_W = 7;
    localparam int PROD_W = POS_W + QUOT_W;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLUMN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_COLUMN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ROW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_GLYPH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_GLYPH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_GLYPH = 3'd7;

    typedef struct packed {
        logic signed [POS_W-1:0] range_min;
        logic signed [POS_W-1:0] range_max;
        logic [COL_W-1:0]        first_column;
        logic [COL_W-1:0]        last_column;
        logic [ROW_W-1:0]        display_row;
        logic [GLYPH_W-1:0]      empty_glyph;
        logic [GLYPH_W-1:0]      full_glyph;
        logic [GLYPH_W-1:0]      half_glyph;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0]  first;
        logic [COL_W-1:0]  last;
        logic [QUOT_W-1:0] half_idx;
        logic              odd;
    } job_t;

endpackage

/* hw/rtl/lbg_front.sv */
// front end: takes positions, clamps and maps them to a half-cell index
`timescale 1ns / 1ps
module lbg_front
    import lbg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [POS_W-1:0] s_tdata,
    output logic             push_valid,
    input  logic             push_ready,
    output job_t             push_job
);

    typedef enum logic [5:0] {
        FR_IDLE  = 6'b000001,
        FR_CLAMP = 6'b000010,
        FR_SUB   = 6'b000100,
        FR_MUL   = 6'b001000,
        FR_DIV   = 6'b010000,
        FR_PUSH  = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic                    in_full_reg;
    logic signed [POS_W-1:0] in_pos_reg;
    logic signed [POS_W-1:0] p_reg;
    logic [POS_W-1:0]        a_reg;
    logic [POS_W-1:0]        d_reg;
    logic                    eq_reg;
    logic [PROD_W-1:0]       rem_reg;
    logic [PROD_W-1:0]       dshift_reg;
    logic [QUOT_W-1:0]       q_reg;
    logic [2:0]              div_cnt_reg;

    logic                    take;
    logic                    asc;
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] p_clamp;
    logic [COL_W-1:0]        first_sat;
    logic [COL_W-1:0]        last_lim;
    logic [COL_W-1:0]        last_sat;
    logic [QUOT_W-1:0]       span;
    logic                    ge;
    logic [QUOT_W-1:0]       q_eff;
    logic [QUOT_W:0]         k;

    assign take     = (state_reg == FR_CLAMP);
    assign s_tready = !in_full_reg || take;

    assign asc = cfg.range_min < cfg.range_max;
    assign lo  = asc ? cfg.range_min : cfg.range_max;
    assign hi  = asc ? cfg.range_max : cfg.range_min;

    always_comb begin
        if (in_pos_reg < lo) begin
            p_clamp = lo;
        end else if (in_pos_reg > hi) begin
            p_clamp = hi;
        end else begin
            p_clamp = in_pos_reg;
        end
    end

    assign first_sat = (cfg.first_column > COL_LAST) ? COL_LAST : cfg.first_column;
    assign last_lim  = (cfg.last_column > COL_LAST) ? COL_LAST : cfg.last_column;
    assign last_sat  = (last_lim < first_sat) ? first_sat : last_lim;
    assign span      = {last_sat - first_sat, 1'b1};

    assign ge    = rem_reg >= dshift_reg;
    assign q_eff = eq_reg ? '0 : q_reg;
    assign k     = {1'b0, q_eff} + {1'b0, first_sat, 1'b0};

    assign push_valid        = (state_reg == FR_PUSH);
    assign push_job.first    = first_sat;
    assign push_job.last     = last_sat;
    assign push_job.half_idx = k[QUOT_W:1];
    assign push_job.odd      = k[0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:  if (in_full_reg) state_next = FR_CLAMP;
            FR_CLAMP: state_next = FR_SUB;
            FR_SUB:   state_next = FR_MUL;
            FR_MUL:   state_next = FR_DIV;
            FR_DIV:   if (div_cnt_reg == '0) state_next = FR_PUSH;
            FR_PUSH:  if (push_ready) state_next = FR_IDLE;
            default:  state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FR_IDLE;
            in_full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) begin
                in_full_reg <= 1'b1;
            end else if (take) begin
                in_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pos_reg <= s_tdata;
        end
        case (state_reg)
            FR_CLAMP: p_reg <= p_clamp;
            FR_SUB: begin
                a_reg  <= asc ? p_reg - cfg.range_min : cfg.range_min - p_reg;
                d_reg  <= asc ? cfg.range_max - cfg.range_min
                              : cfg.range_min - cfg.range_max;
                eq_reg <= cfg.range_min == cfg.range_max;
            end
            FR_MUL: begin
                rem_reg     <= PROD_W'(a_reg) * PROD_W'(span);
                dshift_reg  <= PROD_W'({d_reg, (QUOT_W-1)'(0)});
                div_cnt_reg <= 3'(QUOT_W - 1);
            end
            FR_DIV: begin
                if (ge) begin
                    rem_reg <= rem_reg - dshift_reg;
                end
                q_reg       <= {q_reg[QUOT_W-2:0], ge};
                dshift_reg  <= dshift_reg >> 1;
                div_cnt_reg <= div_cnt_reg - 3'd1;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/lbg_queue.sv */
// two-entry job queue between the front and back ends
`timescale 1ns / 1ps
module lbg_queue
    import lbg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/lbg_back.sv */
// back end: walks the columns of a job and emits one cell per cycle unless the output stalls
`timescale 1ns / 1ps
module lbg_back
    import lbg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  job_valid,
    output logic                  job_pop,
    input  job_t                  job,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic [COL_W-1:0]      col_reg;
    logic                  started_reg;

    logic                  load_en;
    logic                  emit;
    logic [COL_W-1:0]      col;
    logic                  at_last;
    logic [GLYPH_W-1:0]    glyph;

    assign load_en = !out_valid_reg || m_tready;
    assign emit    = load_en && job_valid;
    assign col     = started_reg ? col_reg : job.first;
    assign at_last = col == job.last;
    assign job_pop = emit && at_last;

    always_comb begin
        if (col == job.first) begin
            glyph = LEFT_GLYPH;
        end else if (at_last) begin
            glyph = RIGHT_GLYPH;
        end else if ({1'b0, col} < job.half_idx) begin
            glyph = cfg.full_glyph;
        end else if (({1'b0, col} == job.half_idx) && job.odd) begin
            glyph = cfg.half_glyph;
        end else begin
            glyph = cfg.empty_glyph;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
            started_reg   <= !at_last;
        end else if (load_en) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= {glyph, cfg.display_row, col};
            out_last_reg <= at_last;
            col_reg      <= col + COL_W'(1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/lcd_bar_graph_cell_generator.sv */
// Top level: registers, front end, job queue and cell emitting back end.
// Each position passes the clamp, subtract, multiply and divide states of the front end,
// whose divide state runs a 7-step quotient loop, then the job queue and the back end.
// The back end emits one cell per cycle unless stalled, last - first + 1 cells a position
// after column saturation; the front end maps the next position while cells go out.
// Synchronous active-low reset clears all control state and loads register defaults.
`timescale 1ns / 1ps
module lcd_bar_graph_cell_generator
    import lbg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [POS_W-1:0]      s_tdata,  // position
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // cell_column, cell_row, glyph
    output logic                  m_tlast
);

    cfg_t cfg_reg;
    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_min    <= 32'sd0;
            cfg_reg.range_max    <= 32'sd100;
            cfg_reg.first_column <= 6'd0;
            cfg_reg.last_column  <= 6'd7;
            cfg_reg.display_row  <= 2'd0;
            cfg_reg.empty_glyph  <= 8'd20;
            cfg_reg.full_glyph   <= 8'd255;
            cfg_reg.half_glyph   <= 8'd255;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RANGE_MIN:    cfg_reg.range_min    <= cfg_data;
                REG_RANGE_MAX:    cfg_reg.range_max    <= cfg_data;
                REG_FIRST_COLUMN: cfg_reg.first_column <= cfg_data[COL_W-1:0];
                REG_LAST_COLUMN:  cfg_reg.last_column  <= cfg_data[COL_W-1:0];
                REG_DISPLAY_ROW:  cfg_reg.display_row  <= cfg_data[ROW_W-1:0];
                REG_EMPTY_GLYPH:  cfg_reg.empty_glyph  <= cfg_data[GLYPH_W-1:0];
                REG_FULL_GLYPH:   cfg_reg.full_glyph   <= cfg_data[GLYPH_W-1:0];
                REG_HALF_GLYPH:   cfg_reg.half_glyph   <= cfg_data[GLYPH_W-1:0];
                default: ;
            endcase
        end
    end

    lbg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    lbg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    lbg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (pop_valid),
        .job_pop   (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* hw/rtl/lbg_checker.sv */
// port checker for the bar graph cell generator and its bind
`timescale 1ns / 1ps
module lbg_checker
    import lbg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    logic             mid_run_reg;
    logic [COL_W-1:0] prev_col_reg;
    logic [ROW_W-1:0] prev_row_reg;
    logic             out_acc;

    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_run_reg <= 1'b0;
        end else if (out_acc) begin
            mid_run_reg <= !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_acc) begin
            prev_col_reg <= m_tdata[COL_W-1:0];
            prev_row_reg <= m_tdata[COL_W+ROW_W-1:COL_W];
        end
    end

    // stalled cell holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // columns step by one within a run
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && mid_run_reg |-> m_tdata[COL_W-1:0] == prev_col_reg + COL_W'(1))
        else $error("column skipped or repeated");

    // row constant within a run
    a_row: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && mid_run_reg |-> m_tdata[COL_W+ROW_W-1:COL_W] == prev_row_reg)
        else $error("row changed inside a run");

    // run opens with the left bracket
    a_left: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && !mid_run_reg |-> m_tdata[OUT_DATA_W-1:COL_W+ROW_W] == LEFT_GLYPH)
        else $error("run does not start with left bracket");

endmodule

bind lcd_bar_graph_cell_generator lbg_checker u_lbg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/bar_cell_check.sv */
// checker for the bar graph cell generator: predicts each bar and compares the cells
`timescale 1ns / 1ps
module bar_cell_check
    import lbg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [POS_W-1:0]      s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    output int                    mismatches,
    output int                    pending_cells,
    output int                    cells_checked
);

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } bar_cell_t;

    cfg_t      shadow;
    bar_cell_t expected_cells[$];
    int        errors = 0;
    int        seen = 0;

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        errors++;
        $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    task automatic predict_bar(input logic [POS_W-1:0] raw);
        longint      pos, lo, hi, rmin, rmax, quot;
        int unsigned first, last, k, mid, col;
        bar_cell_t   c;
        rmin = $signed(shadow.range_min);
        rmax = $signed(shadow.range_max);
        pos = $signed(raw);
        first = (shadow.first_column > COL_LAST) ? COL_LAST : shadow.first_column;
        last = (shadow.last_column > COL_LAST) ? COL_LAST : shadow.last_column;
        if (last < first) begin
            last = first;
        end
        lo = (rmin < rmax) ? rmin : rmax;
        hi = (rmin < rmax) ? rmax : rmin;
        if (pos < lo) begin
            pos = lo;
        end
        if (pos > hi) begin
            pos = hi;
        end
        if (rmax == rmin) begin
            k = 2 * first;
        end else begin
            // 64-bit product, quotient truncates toward zero
            quot = ((pos - rmin) * longint'(2 * (last - first) + 1)) / (rmax - rmin);
            k = 32'(quot) + 2 * first;
        end
        mid = k >> 1;
        for (col = first; col <= last; col++) begin
            if (col == first) begin
                c.glyph = LEFT_GLYPH;
            end else if (col == last) begin
                c.glyph = RIGHT_GLYPH;
            end else if (col < mid) begin
                c.glyph = shadow.full_glyph;
            end else if (col == mid && k[0]) begin
                c.glyph = shadow.half_glyph;
            end else begin
                c.glyph = shadow.empty_glyph;
            end
            c.column = COL_W'(col);
            c.row = shadow.display_row;
            c.last = (col == last);
            expected_cells.push_back(c);
        end
    endtask

    always @(posedge aclk) begin
        bar_cell_t want, got;
        if (!aresetn) begin
            shadow.range_min = 0;
            shadow.range_max = 100;
            shadow.first_column = 0;
            shadow.last_column = 7;
            shadow.display_row = 0;
            shadow.empty_glyph = 20;
            shadow.full_glyph = 255;
            shadow.half_glyph = 255;
            expected_cells.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.column = m_tdata[COL_W-1:0];
                got.row = m_tdata[COL_W +: ROW_W];
                got.glyph = m_tdata[COL_W+ROW_W +: GLYPH_W];
                got.last = m_tlast;
                seen++;
                if (expected_cells.size() == 0) begin
                    errors++;
                    $display("%0t ns: cell expected none, got column %0d glyph %0d",
                             $time, got.column, got.glyph);
                end else begin
                    want = expected_cells.pop_front();
                    if (got.column !== want.column) report("cell_column", want.column, got.column);
                    if (got.row !== want.row) report("cell_row", want.row, got.row);
                    if (got.glyph !== want.glyph) report("glyph", want.glyph, got.glyph);
                    if (got.last !== want.last) report("run_last", want.last, got.last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RANGE_MIN:    shadow.range_min = cfg_data;
                    REG_RANGE_MAX:    shadow.range_max = cfg_data;
                    REG_FIRST_COLUMN: shadow.first_column = cfg_data[COL_W-1:0];
                    REG_LAST_COLUMN:  shadow.last_column = cfg_data[COL_W-1:0];
                    REG_DISPLAY_ROW:  shadow.display_row = cfg_data[ROW_W-1:0];
                    REG_EMPTY_GLYPH:  shadow.empty_glyph = cfg_data[GLYPH_W-1:0];
                    REG_FULL_GLYPH:   shadow.full_glyph = cfg_data[GLYPH_W-1:0];
                    REG_HALF_GLYPH:   shadow.half_glyph = cfg_data[GLYPH_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_bar(s_tdata);
            end
        end
        mismatches <= errors;
        pending_cells <= expected_cells.size();
        cells_checked <= seen;
    end

endmodule

/* tb/tb.sv */
// testbench top: drives positions and register writes into the bar graph cell generator
`timescale 1ns / 1ps
module tb;
    import lbg_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 32;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [POS_W-1:0]      s_tdata;   // position
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // cell_column, cell_row, glyph
    logic                  m_tlast;

    int                    mismatches;
    int                    pending_cells;
    int                    cells_checked;
    logic                  idle_en;
    logic                  hold_req;
    logic                  hold_done;
    logic signed [31:0]    cur_min;
    logic signed [31:0]    cur_max;
    int                    positions_sent = 0;
    int                    settings_used = 1;
    int                    quiet_cycles;

    lcd_bar_graph_cell_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    bar_cell_check bar_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending_cells (pending_cells),
        .cells_checked (cells_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // cell receiver: random stalls plus one long hold-off
    initial begin
        m_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic signed [31:0] lo_val, hi_val,
                                 input int first, last, row,
                                 input logic [7:0] empty, full, half);
        write_reg(REG_RANGE_MIN, lo_val);
        write_reg(REG_RANGE_MAX, hi_val);
        write_reg(REG_FIRST_COLUMN, 32'(first));
        write_reg(REG_LAST_COLUMN, 32'(last));
        write_reg(REG_DISPLAY_ROW, 32'(row));
        write_reg(REG_EMPTY_GLYPH, {24'd0, empty});
        write_reg(REG_FULL_GLYPH, {24'd0, full});
        write_reg(REG_HALF_GLYPH, {24'd0, half});
        cfg_valid <= 1'b0;
        cur_min = lo_val;
        cur_max = hi_val;
        settings_used++;
    endtask

    task automatic send_position(input logic [POS_W-1:0] pos);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pos;
        do @(posedge aclk); while (!s_tready);
        positions_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cells != 0);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        longint          lo, hi;
        longint unsigned r;
        lo = (cur_min < cur_max) ? cur_min : cur_max;
        hi = (cur_min < cur_max) ? cur_max : cur_min;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return cur_min;
            2: return cur_max;
            3: return cur_min - 1;
            4: return cur_max + 1;
            default: return POS_W'(lo + longint'(r % longint'(hi - lo + 1)));
        endcase
    endfunction

    initial begin
        logic signed [31:0] a, b;
        int                 f, l;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        aresetn = 1'b0;
        cur_min = 0;
        cur_max = 100;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: clamping, odd half index, extreme positions
        send_position(0);
        send_position(100);
        send_position(50);
        send_position(7);
        send_position(20);
        send_position(-1);
        send_position(101);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        wait_drained();

        // full 32-bit range
        apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 3, 12, 3, 8'h00, 8'hFF, 8'hAA);
        send_position(32'h8000_0000);
        send_position(32'h7FFF_FFFF);
        send_position(0);
        wait_drained();

        // equal bounds give an empty bar
        apply_setting(5, 5, 0, 39, 1, 8'h11, 8'h22, 8'h33);
        send_position(5);
        send_position(-7);
        wait_drained();

        // reversed bounds
        apply_setting(1000, -1000, 2, 20, 2, 8'h55, 8'hCC, 8'h0F);
        send_position(-2000);
        send_position(0);
        send_position(2000);
        send_position(999);
        wait_drained();

        // columns past the display edge
        apply_setting(0, 100, 63, 63, 0, 8'h20, 8'hF0, 8'h7E);
        send_position(50);
        wait_drained();
        apply_setting(0, 100, 30, 55, 1, 8'h20, 8'hF0, 8'h7E);
        send_position(60);
        wait_drained();

        // last column below first column
        apply_setting(0, 100, 10, 4, 2, 8'h20, 8'hF0, 8'h7E);
        send_position(100);
        wait_drained();

        // widest bar
        apply_setting(-100, 100, 0, 39, 3, 8'h01, 8'hFE, 8'h80);
        send_position(0);
        send_position(100);
        send_position(-100);
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                // receiver stalls long while full-width bars keep coming
                idle_en <= 1'b0;
                hold_req <= 1'b1;
                apply_setting(-1000, 1000, 0, 39, $urandom_range(0, 3),
                              8'($urandom), 8'($urandom), 8'($urandom));
                repeat (10) send_position(pick_position());
            end else begin
                idle_en <= (ph < 10);
                case ($urandom_range(0, 5))
                    0: begin
                        a = 32'sh8000_0000;
                        b = 32'sh7FFF_FFFF;
                        if ($urandom_range(0, 1) == 1) begin
                            {a, b} = {b, a};
                        end
                    end
                    1: begin
                        a = $urandom;
                        b = a;
                    end
                    2: begin
                        a = $urandom;
                        b = $urandom;
                    end
                    3: begin
                        a = $urandom_range(0, 200) - 100;
                        b = a + $urandom_range(1, 300);
                    end
                    4: begin
                        b = $urandom_range(0, 200) - 100;
                        a = b + $urandom_range(1, 300);
                    end
                    default: begin
                        a = 32'sh8000_0000;
                        b = $urandom;
                    end
                endcase
                f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 20);
                l = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : f + $urandom_range(0, 19);
                apply_setting(a, b, f, l, $urandom_range(0, 3),
                              8'($urandom), 8'($urandom), 8'($urandom));
                repeat (22) send_position(pick_position());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run: %0d positions over %0d register settings, %0d cells compared",
                 positions_sent, settings_used, cells_checked);
        $display("run: clamped, equal and reversed ranges, saturated and crossed columns, long stall");
        if (mismatches == 0 && pending_cells == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lbg_pkg.sv
hw/rtl/lbg_front.sv
hw/rtl/lbg_queue.sv
hw/rtl/lbg_back.sv
hw/rtl/lcd_bar_graph_cell_generator.sv
hw/rtl/lbg_checker.sv
tb/bar_cell_check.sv
tb/tb.sv
